FILE: design/ttab_pkg.sv
// ----------------------------------------------------------------------------
// ttab_pkg
// Shared types and constants of the direct-mapped transposition table:
// table geometry, action codes, command and entry layouts, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ttab_pkg;

	// Table geometry (power of two, at least two entries)
	localparam int TABLE_ENTRIES = 65536;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Action codes on the input port
	localparam logic [1:0] ACT_PROBE = 2'd0;
	localparam logic [1:0] ACT_STORE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Classified operation
	typedef enum logic [1:0] {
		OP_PROBE,
		OP_STORE,
		OP_CLEAR,
		OP_NOP
	} op_t;

	// One classified command
	typedef struct packed {
		op_t                op;
		logic [63:0]        key;
		logic signed [7:0]  depth;
		logic signed [15:0] score;
		logic [1:0]         bound;
		logic [15:0]        move;
	} cmd_t;

	// One table entry
	typedef struct packed {
		logic [63:0]        key;
		logic signed [7:0]  depth;
		logic signed [15:0] score;
		logic [1:0]         bound;
		logic [15:0]        move;
	} entry_t;

	// Empty entry: key zero, depth minus one
	localparam entry_t EMPTY_ENTRY = '{
		key:   64'd0,
		depth: 8'hFF,
		score: 16'd0,
		bound: 2'd0,
		move:  16'd0
	};

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EVAL,
		ST_CLEAR,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: design/ttab_front.sv
// ----------------------------------------------------------------------------
// ttab_front
// Input stage: accepts an item, classifies its action and pushes the
// command into the queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ttab_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          action,
	input  wire logic [63:0]         key,
	input  wire logic signed [7:0]   depth,
	input  wire logic signed [15:0]  score,
	input  wire logic [1:0]          bound,
	input  wire logic [15:0]         move,
	input  wire logic                hold,
	input  wire logic                q_full,
	output logic                     q_push,
	output ttab_pkg::cmd_t           q_cmd
);

	logic           cmd_valid_s1;
	ttab_pkg::cmd_t cmd_s1;
	ttab_pkg::cmd_t cmd_dec;
	logic           accept;

	// Push when the queue has room; hold the input while blocked
	assign q_push   = cmd_valid_s1 && !q_full;
	assign in_stall = hold || (cmd_valid_s1 && q_full);
	assign accept   = in_valid && !in_stall;
	assign q_cmd    = cmd_s1;

	// Classify the action
	always_comb begin
		cmd_dec.key   = key;
		cmd_dec.depth = depth;
		cmd_dec.score = score;
		cmd_dec.bound = bound;
		cmd_dec.move  = move;
		case (action)
			ttab_pkg::ACT_PROBE: cmd_dec.op = ttab_pkg::OP_PROBE;
			ttab_pkg::ACT_STORE: cmd_dec.op = ttab_pkg::OP_STORE;
			ttab_pkg::ACT_CLEAR: cmd_dec.op = ttab_pkg::OP_CLEAR;
			default:             cmd_dec.op = ttab_pkg::OP_NOP;
		endcase
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (accept) begin
			cmd_valid_s1 <= 1'b1;
		end else if (q_push) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

`default_nettype wire

FILE: design/ttab_queue.sv
// ----------------------------------------------------------------------------
// ttab_queue
// Short command FIFO that decouples the front stage from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ttab_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ttab_pkg::cmd_t cmd_in,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output ttab_pkg::cmd_t      cmd_out
);

	localparam logic [ttab_pkg::QPTR_W-1:0] PTR_LAST =
		ttab_pkg::QPTR_W'(ttab_pkg::QUEUE_DEPTH - 1);
	localparam logic [ttab_pkg::QCNT_W-1:0] CNT_FULL =
		ttab_pkg::QCNT_W'(ttab_pkg::QUEUE_DEPTH);

	ttab_pkg::cmd_t                slot_q [ttab_pkg::QUEUE_DEPTH];
	logic [ttab_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ttab_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ttab_pkg::QCNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign cmd_out   = slot_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Write the slot
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Never overrun or underrun the FIFO
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("ttab_queue: push into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("ttab_queue: pop from an empty queue");

endmodule

`default_nettype wire

FILE: design/ttab_back.sv
// ----------------------------------------------------------------------------
// ttab_back
// Execution back end: owns the entry memory, runs probes, stores and
// clearing passes, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttab_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire ttab_pkg::cmd_t      q_cmd,
	output logic                     q_pop,
	output logic                     init_busy,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     hit,
	output logic                     written,
	output logic signed [7:0]        found_depth,
	output logic signed [15:0]       found_score,
	output logic [1:0]               found_bound,
	output logic [15:0]              found_move
);

	// Entry memory
	ttab_pkg::entry_t tbl_mem [ttab_pkg::TABLE_ENTRIES];

	ttab_pkg::state_t             state_q;
	ttab_pkg::state_t             state_nxt;
	ttab_pkg::cmd_t               cmd_q;
	ttab_pkg::entry_t             rd_data_q;
	logic [ttab_pkg::IDX_W-1:0]   clr_cnt_q;
	logic                         clr_last;
	logic                         clr_inc;
	logic                         cmd_load;

	logic                         rd_en;
	logic [ttab_pkg::IDX_W-1:0]   rd_idx;
	logic                         mem_we;
	logic [ttab_pkg::IDX_W-1:0]   wr_idx;
	ttab_pkg::entry_t             wr_data;

	logic                         out_valid_q;
	logic                         out_free;
	logic                         out_load;
	logic                         res_hit;
	logic                         res_written;
	ttab_pkg::entry_t             res_entry;

	logic                         key_match;
	logic                         probe_hit;
	logic                         replace;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign init_busy = (state_q == ttab_pkg::ST_INIT);
	assign clr_last  = (clr_cnt_q == '1);
	assign rd_idx    = q_cmd.key[ttab_pkg::IDX_W-1:0];

	// Compare the read entry with the command
	assign key_match = (rd_data_q.key == cmd_q.key);
	assign probe_hit = key_match && !rd_data_q.depth[7];
	assign replace   = ($signed(rd_data_q.depth) <= $signed(cmd_q.depth)) || !key_match;

	// Sequencer: next state and datapath controls
	always_comb begin
		state_nxt   = state_q;
		q_pop       = 1'b0;
		cmd_load    = 1'b0;
		rd_en       = 1'b0;
		mem_we      = 1'b0;
		wr_idx      = cmd_q.key[ttab_pkg::IDX_W-1:0];
		wr_data     = '{key: cmd_q.key, depth: cmd_q.depth, score: cmd_q.score,
			bound: cmd_q.bound, move: cmd_q.move};
		clr_inc     = 1'b0;
		out_load    = 1'b0;
		res_hit     = 1'b0;
		res_written = 1'b0;
		res_entry   = '0;
		case (state_q)
			ttab_pkg::ST_INIT: begin
				mem_we  = 1'b1;
				wr_idx  = clr_cnt_q;
				wr_data = ttab_pkg::EMPTY_ENTRY;
				clr_inc = 1'b1;
				if (clr_last) begin
					state_nxt = ttab_pkg::ST_IDLE;
				end
			end
			ttab_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop    = 1'b1;
					cmd_load = 1'b1;
					case (q_cmd.op)
						ttab_pkg::OP_PROBE,
						ttab_pkg::OP_STORE: begin
							rd_en     = 1'b1;
							state_nxt = ttab_pkg::ST_EVAL;
						end
						ttab_pkg::OP_CLEAR: state_nxt = ttab_pkg::ST_CLEAR;
						default:            state_nxt = ttab_pkg::ST_FIN;
					endcase
				end
			end
			ttab_pkg::ST_EVAL: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = ttab_pkg::ST_IDLE;
					case (cmd_q.op)
						ttab_pkg::OP_PROBE: begin
							res_hit = probe_hit;
							if (probe_hit) begin
								res_entry = rd_data_q;
							end
						end
						ttab_pkg::OP_STORE: begin
							mem_we      = replace;
							res_written = replace;
						end
						default: ;
					endcase
				end
			end
			ttab_pkg::ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_idx  = clr_cnt_q;
				wr_data = ttab_pkg::EMPTY_ENTRY;
				clr_inc = 1'b1;
				if (clr_last) begin
					state_nxt = ttab_pkg::ST_FIN;
				end
			end
			ttab_pkg::ST_FIN: begin
				if (out_free) begin
					out_load    = 1'b1;
					res_written = (cmd_q.op == ttab_pkg::OP_CLEAR);
					state_nxt   = ttab_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ttab_pkg::ST_IDLE;
		endcase
	end

	// State and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ttab_pkg::ST_INIT;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (clr_inc) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Hold the current command
	always_ff @(posedge clk) begin
		if (cmd_load) begin
			cmd_q <= q_cmd;
		end
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= tbl_mem[rd_idx];
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			hit         <= res_hit;
			written     <= res_written;
			found_depth <= res_entry.depth;
			found_score <= res_entry.score;
			found_bound <= res_entry.bound;
			found_move  <= res_entry.move;
		end
	end

	// No command leaves the queue during a sweep or while one is in flight
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ttab_pkg::ST_IDLE))
		else $error("ttab_back: queue popped outside idle");

	// Lookup writes only come from stores
	a_eval_write_store: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == ttab_pkg::ST_EVAL) |-> (cmd_q.op == ttab_pkg::OP_STORE))
		else $error("ttab_back: table written by a non-store lookup");

	// A finished clear sweep always reports its result next
	a_clear_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttab_pkg::ST_CLEAR && clr_last) |=> (state_q == ttab_pkg::ST_FIN))
		else $error("ttab_back: clear sweep did not end in result");

	// A result is never loaded over one that is still stalled
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load)
		else $error("ttab_back: stalled result overwritten");

endmodule

`default_nettype wire

FILE: design/direct_mapped_transposition_table_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table_top
// Direct-mapped transposition table keeping the deeper result per key:
// probe, conditional store and whole-table clear over a 64-bit key.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   input    | in_valid / in_stall  | action key depth score bound move
//   output   | out_valid / out_stall| hit written found_depth found_score
//            |                      | found_bound found_move
//
// With the back end idle, an accepted probe or store passes the input-stage
// register, the queue and the registered entry read, then loads the output
// register and raises out_valid. The back end takes no new item until it is
// through with the last: it reads the entry memory in ST_IDLE, then compares
// and writes back in ST_EVAL. A clear sweeps the memory one entry a cycle.
// After reset a clearing pass runs while in_stall stays high. A stalled result
// holds in the output register; up to four further items are taken meanwhile:
// one in the back end, two in the queue and one in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_transposition_table_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          action,
	input  wire logic [63:0]         key,
	input  wire logic signed [7:0]   depth,
	input  wire logic signed [15:0]  score,
	input  wire logic [1:0]          bound,
	input  wire logic [15:0]         move,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     hit,
	output logic                     written,
	output logic signed [7:0]        found_depth,
	output logic signed [15:0]       found_score,
	output logic [1:0]               found_bound,
	output logic [15:0]              found_move
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_not_empty;
	logic           init_busy;
	ttab_pkg::cmd_t front_cmd;
	ttab_pkg::cmd_t queue_cmd;

	// Accept and classify
	ttab_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.key      (key),
		.depth    (depth),
		.score    (score),
		.bound    (bound),
		.move     (move),
		.hold     (init_busy),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (front_cmd)
	);

	// Decouple front and back
	ttab_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.cmd_in    (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.cmd_out   (queue_cmd)
	);

	// Execute against the table
	ttab_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_cmd       (queue_cmd),
		.q_pop       (q_pop),
		.init_busy   (init_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.written     (written),
		.found_depth (found_depth),
		.found_score (found_score),
		.found_bound (found_bound),
		.found_move  (found_move)
	);

endmodule

`default_nettype wire

FILE: sim/direct_mapped_transposition_table_top_tb.sv
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table_top_tb
// Self-checking bench for the transposition table. A scoreboard keeps a sparse
// shadow of the table, predicts every probe, store, clear and unused action,
// and checks each result in order. A directed opener covers empty slots,
// depth ties, key collisions, extremes and clears. It is followed by random
// items over a small pool of colliding keys, with bursty input and a patterned
// output stall that includes one long hold-off.
// ----------------------------------------------------------------------------
module direct_mapped_transposition_table_top_tb;

	import ttab_pkg::*;

	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam logic [1:0] BOUND_EXACT  = 2'd0;
	localparam logic [1:0] BOUND_LOWER  = 2'd1;
	localparam logic [1:0] BOUND_UPPER  = 2'd2;
	localparam logic [1:0] BOUND_BAD    = 2'd3;
	localparam int         RANDOM_ITEMS = 550;
	localparam int         HOLD_CYCLES  = 400;
	localparam longint     LIMIT_CYCLES = 3_000_000;

	// One result item as seen on the output ports
	typedef struct packed {
		logic               hit;
		logic               written;
		logic signed [7:0]  depth;
		logic signed [15:0] score;
		logic [1:0]         bound;
		logic [15:0]        move;
	} lookup_t;

	// Shadow table and queue of expected lookups
	class tt_scoreboard;
		entry_t  slots[int unsigned];
		lookup_t expected_q[$];
		int      errors;
		int      accepted;
		int      probes, hits, stores, replaced, clears, unused;

		function void note_item(input logic [1:0] act, input logic [63:0] k,
				input logic signed [7:0] d, input logic signed [15:0] s,
				input logic [1:0] b, input logic [15:0] m);
			lookup_t     r;
			entry_t      e;
			int unsigned idx;
			r = '0;
			idx = 32'(k & (64'(TABLE_ENTRIES) - 64'd1));
			e = slots.exists(idx) ? slots[idx] : EMPTY_ENTRY;
			accepted++;
			case (act)
				ACT_PROBE: begin
					probes++;
					if (e.key == k && e.depth >= 0) begin
						hits++;
						r.hit   = 1'b1;
						r.depth = e.depth;
						r.score = e.score;
						r.bound = e.bound;
						r.move  = e.move;
					end
				end
				ACT_STORE: begin
					stores++;
					// replace when not shallower or when another key owns the slot
					if (e.depth <= d || e.key != k) begin
						replaced++;
						slots[idx] = '{key: k, depth: d, score: s, bound: b, move: m};
						r.written = 1'b1;
					end
				end
				ACT_CLEAR: begin
					clears++;
					slots.delete();
					r.written = 1'b1;
				end
				default: unused++;
			endcase
			expected_q.push_back(r);
		endfunction

		function void compare_field(input string name, input int expv, input int gotv);
			if (expv != gotv) begin
				errors++;
				$error("%s: expected %0d, got %0d", name, expv, gotv);
			end
		endfunction

		function void check_result(input lookup_t got);
			lookup_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$error("result with no item pending: hit %0d written %0d",
					got.hit, got.written);
				return;
			end
			want = expected_q.pop_front();
			compare_field("hit", int'(want.hit), int'(got.hit));
			compare_field("written", int'(want.written), int'(got.written));
			compare_field("found_depth", int'(want.depth), int'(got.depth));
			compare_field("found_score", int'(want.score), int'(got.score));
			compare_field("found_bound", int'(want.bound), int'(got.bound));
			compare_field("found_move", int'(want.move), int'(got.move));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         action = ACT_PROBE;
	logic [63:0]        key = '0;
	logic signed [7:0]  depth = '0;
	logic signed [15:0] score = '0;
	logic [1:0]         bound = BOUND_EXACT;
	logic [15:0]        move = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic               written;
	logic signed [7:0]  found_depth;
	logic signed [15:0] found_score;
	logic [1:0]         found_bound;
	logic [15:0]        found_move;

	tt_scoreboard board = new();

	direct_mapped_transposition_table_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key         (key),
		.depth       (depth),
		.score       (score),
		.bound       (bound),
		.move        (move),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.written     (written),
		.found_depth (found_depth),
		.found_score (found_score),
		.found_bound (found_bound),
		.found_move  (found_move)
	);

	always #6 clk = ~clk;

	// Offer one item from the falling edge, hold it until taken
	task automatic offer_item(input logic [1:0] a, input logic [63:0] k,
			input logic signed [7:0] d, input logic signed [15:0] s,
			input logic [1:0] b, input logic [15:0] m);
		@(negedge clk);
		in_valid <= 1'b1;
		action   <= a;
		key      <= k;
		depth    <= d;
		score    <= s;
		bound    <= b;
		move     <= m;
		do
			@(posedge clk);
		while (in_stall);
		board.note_item(a, k, d, s, b, m);
	endtask

	// Drop valid for a number of cycles
	task automatic idle_input(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Draw a key from a small pool of colliding slots, now and then a wild one
	function automatic logic [63:0] pick_key();
		logic [63:0]      hi;
		logic [IDX_W-1:0] lo;
		if ($urandom_range(0, 15) == 0)
			return {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: lo = '0;
			1: lo = '1;
			2: lo = IDX_W'(1) << (IDX_W - 1);
			default: lo = IDX_W'($urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 3))
			0: hi = '0;
			1: hi = '1;
			default: hi = 64'($urandom_range(1, 3));
		endcase
		return (hi << IDX_W) | 64'(lo);
	endfunction

	// Mostly small depths so that ties and near misses are common
	function automatic logic signed [7:0] pick_depth();
		case ($urandom_range(0, 7))
			0: return 8'($urandom_range(0, 255));
			1: return -8'sd128;
			2: return 8'sd127;
			default: return 8'($urandom_range(0, 12)) - 8'd2;
		endcase
	endfunction

	// Check every result taken at a rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result('{hit: hit, written: written, depth: found_depth,
				score: found_score, bound: found_bound, move: found_move});
	end

	// Stall the output on shifting patterns, with one long hold-off
	initial begin : receiver
		int         mode;
		int         mode_left;
		int         hold_left;
		bit         held;
		logic [7:0] pattern;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		pattern = 8'h00;
		forever begin
			@(negedge clk);
			if (!held && board.accepted >= 120) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 60);
					pattern = 8'($urandom);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: begin
						pattern = {pattern[6:0], pattern[7]};
						out_stall <= pattern[0];
					end
				endcase
			end
		end
	end

	// End the run if it hangs
	initial begin : watchdog
		#(LIMIT_CYCLES * 12);
		$display("direct_mapped_transposition_table_top: mismatch");
		$finish;
	end

	initial begin : stimulus
		int                 sent;
		int                 burst;
		int                 clears_left;
		int                 roll;
		logic [1:0]         act;
		logic [63:0]        k;
		logic [63:0]        last_key;
		logic signed [7:0]  d;
		logic [1:0]         b;
		sent = 0;
		clears_left = 4;
		last_key = '0;

		// Hold reset, then release it on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty slot: key zero with depth minus one never hits
		offer_item(ACT_PROBE, 64'd0, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		offer_item(ACT_STORE, 64'd0, -8'sd1, 16'sd5, BOUND_LOWER, 16'd1);
		offer_item(ACT_PROBE, 64'd0, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		// Depth zero hits, odd bound code kept as given
		offer_item(ACT_STORE, 64'd0, 8'sd0, -16'sd32768, BOUND_BAD, 16'hFFFF);
		offer_item(ACT_PROBE, 64'd0, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		// Shallower store on the same key is refused
		offer_item(ACT_STORE, 64'd0, -8'sd128, 16'sd1, BOUND_UPPER, 16'd2);
		offer_item(ACT_PROBE, 64'd0, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		// Another key in the same slot always replaces
		offer_item(ACT_STORE, 64'h1 << IDX_W, -8'sd128, 16'sd7, BOUND_LOWER, 16'd3);
		offer_item(ACT_PROBE, 64'd0, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		offer_item(ACT_PROBE, 64'h1 << IDX_W, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		// Top slot with extreme fields, then an equal-depth overwrite
		offer_item(ACT_STORE, '1, 8'sd127, 16'sd32767, BOUND_UPPER, 16'h0000);
		offer_item(ACT_PROBE, '1, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		offer_item(ACT_STORE, '1, 8'sd127, -16'sd1, BOUND_EXACT, 16'h5A5A);
		offer_item(ACT_PROBE, '1, -8'sd1, -16'sd1, BOUND_BAD, 16'hFFFF);
		// Unused action code changes nothing
		offer_item(ACT_UNUSED, '1, -8'sd1, -16'sd1, BOUND_BAD, 16'hFFFF);
		offer_item(ACT_PROBE, '1, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		// Clear empties everything
		offer_item(ACT_CLEAR, 64'hA5A5_A5A5_A5A5_A5A5, 8'sd3, 16'sd3, BOUND_LOWER, 16'd3);
		offer_item(ACT_PROBE, '1, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		offer_item(ACT_PROBE, 64'd0, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		// Same slot, different upper key misses
		offer_item(ACT_STORE, '1, 8'sd5, 16'sd100, BOUND_LOWER, 16'h1234);
		offer_item(ACT_PROBE, 64'h0000_0000_0000_FFFF, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);
		offer_item(ACT_PROBE, '1, 8'sd0, 16'sd0, BOUND_EXACT, 16'd0);

		// Random items in bursts with gaps
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (clears_left > 0 && $urandom_range(0, 139) == 0) begin
					act = ACT_CLEAR;
					clears_left--;
				end else if (roll < 46)
					act = ACT_PROBE;
				else if (roll < 95)
					act = ACT_STORE;
				else
					act = ACT_UNUSED;
				// Revisit the last stored key often to follow up on it
				k = ($urandom_range(0, 2) == 0) ? last_key : pick_key();
				if (act == ACT_STORE)
					last_key = k;
				d = pick_depth();
				b = ($urandom_range(0, 9) == 0) ? BOUND_BAD : 2'($urandom_range(0, 2));
				offer_item(act, k, d, 16'($urandom), b, 16'($urandom));
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 6));
		end
		idle_input(1);

		// Drain, then let the pipeline settle
		while (board.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d items: %0d probes with %0d hits, %0d stores with %0d replaced,",
			board.accepted, board.probes, board.hits, board.stores, board.replaced);
		$display("  %0d clears, %0d unused action codes, %0d errors",
			board.clears, board.unused, board.errors);
		if (board.errors == 0)
			$display("direct_mapped_transposition_table_top: match");
		else
			$display("direct_mapped_transposition_table_top: mismatch");
		$finish;
	end

endmodule
